FILE: src/ring_mask_pixel_generator_macros.svh
// ----------------------------------------------------------------------------
// Ring mask pixel generator assertion macros
// Concurrent assertion wrappers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef RING_MASK_PIXEL_GENERATOR_MACROS_SVH
`define RING_MASK_PIXEL_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define RMPG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring mask pixel generator: assertion failed");
`define RMPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring mask pixel generator: assertion failed");
`else
`define RMPG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RMPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/rmpg_pkg.sv
// ----------------------------------------------------------------------------
// Ring mask pixel generator package
// Field widths and pipeline stage types shared by all modules.
// ----------------------------------------------------------------------------
package rmpg_pkg;

    localparam int CoordW    = 12;
    localparam int CfgW      = 13;
    localparam int DeltaW    = 13;
    localparam int SumW      = 14;
    localparam int SqW       = 24;
    localparam int QuotW     = 22;
    localparam int ResW      = 22;
    localparam int IdxW      = 24;
    localparam int CntW      = 25;
    localparam int InDataW   = 24;
    localparam int OutDataW  = 80;
    localparam int CfgAddrW  = 1;

    localparam logic [CfgAddrW-1:0] RegWidth  = 1'b0;
    localparam logic [CfgAddrW-1:0] RegHeight = 1'b1;

    typedef struct packed {
        logic sq;
        logic q;
        logic v;
        logic out;
    } stage_load_t;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic              frame_start;
    } in_stage_t;

    typedef struct packed {
        logic [SqW-1:0]         sq_x;
        logic [SqW-1:0]         sq_y;
        logic signed [SumW-1:0] dxy;
        logic [IdxW-1:0]        idx;
        logic                   frame_start;
    } sq_stage_t;

    typedef struct packed {
        logic [QuotW-1:0]       q;
        logic signed [SumW-1:0] dxy;
        logic [IdxW-1:0]        idx;
        logic                   frame_start;
    } q_stage_t;

    typedef struct packed {
        logic [ResW-1:0] v;
        logic [IdxW-1:0] idx;
        logic            frame_start;
    } v_stage_t;

    typedef struct packed {
        logic            mask_bit;
        logic [IdxW-1:0] pixel_index;
        logic [IdxW-1:0] black_slot;
        logic [CntW-1:0] black_total;
    } out_stage_t;

endpackage

FILE: src/ring_mask_pixel_generator.sv
// From input accept to m_tvalid an item passes through five register stages.
// Throughput: 1 item per cycle; each stage holds one item and advances when the next frees.
// Output stalls fill the pipeline before s_tready drops.
// Reset: aresetn synchronous, active low; clears stage valids and the black counter,
// loads image_width = 640 and image_height = 480.
// ----------------------------------------------------------------------------
// Ring mask pixel generator
// Per-pixel ring mask bit, linear index and black pixel compaction slot.
// ----------------------------------------------------------------------------
`include "ring_mask_pixel_generator_macros.svh"

module ring_mask_pixel_generator import rmpg_pkg::*; #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgW-1:0]     cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // pixel_x, pixel_y
    input  logic                s_tuser,   // frame_start
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // pixel_index, black_slot, black_total, zero pad
    output logic                m_tuser    // mask_bit
);

    localparam int NumStages = 5;

    logic [CfgW-1:0]      width_reg;
    logic [CfgW-1:0]      height_reg;
    logic [NumStages-1:0] valid_reg;
    logic [NumStages-1:0] valid_next;
    logic [NumStages-1:0] ready;
    logic [NumStages-1:0] load;
    logic [NumStages-1:0] leave;
    stage_load_t          ld;
    in_stage_t            in_reg;
    in_stage_t            in_next;
    sq_stage_t            sq;
    v_stage_t             vs;
    out_stage_t           result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                RegWidth:  width_reg  <= cfg_wr_data;
                RegHeight: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ready[4] = !valid_reg[4] || m_tready;
        ready[3] = !valid_reg[3] || ready[4];
        ready[2] = !valid_reg[2] || ready[3];
        ready[1] = !valid_reg[1] || ready[2];
        ready[0] = !valid_reg[0] || ready[1];
        load[0]  = s_tvalid && ready[0];
        load[1]  = valid_reg[0] && ready[1];
        load[2]  = valid_reg[1] && ready[2];
        load[3]  = valid_reg[2] && ready[3];
        load[4]  = valid_reg[3] && ready[4];
        leave    = {valid_reg[4] && m_tready, load[4:1]};
        valid_next = load | (valid_reg & ~leave);
        ld.sq  = load[1];
        ld.q   = load[2];
        ld.v   = load[3];
        ld.out = load[4];
        in_next.x           = s_tdata[CoordW-1:0];
        in_next.y           = s_tdata[2*CoordW-1:CoordW];
        in_next.frame_start = s_tuser;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            in_reg <= in_next;
        end
    end

    rmpg_square #(
        .MAX_SIDE(MAX_SIDE)
    ) u_square (
        .aclk(aclk),
        .ld(ld),
        .pix(in_reg),
        .image_width(width_reg),
        .image_height(height_reg),
        .sq(sq)
    );

    rmpg_ring u_ring (
        .aclk(aclk),
        .ld(ld),
        .sq(sq),
        .vs(vs)
    );

    rmpg_black_count u_black_count (
        .aclk(aclk),
        .aresetn(aresetn),
        .ld(ld),
        .vs(vs),
        .result(result)
    );

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[4];
    assign m_tuser  = result.mask_bit;
    assign m_tdata  = {7'b0, result.black_total, result.black_slot, result.pixel_index};

    `RMPG_ASSERT_IMPL(a_stall_full, aclk, aresetn, !s_tready, &valid_reg)
    `RMPG_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_tvalid && s_tready, valid_reg[0])
    `RMPG_ASSERT_IMPL(a_out_from_pipe, aclk, aresetn, $rose(m_tvalid), $past(valid_reg[3]))

endmodule

FILE: src/rmpg_square.sv
// ----------------------------------------------------------------------------
// Ring mask offset and square stage
// Centre offsets, their squares and the linear pixel index.
// ----------------------------------------------------------------------------
module rmpg_square import rmpg_pkg::*; #(
    parameter int MAX_SIDE = 4096
) (
    input  logic            aclk,
    input  stage_load_t     ld,
    input  in_stage_t       pix,
    input  logic [CfgW-1:0] image_width,
    input  logic [CfgW-1:0] image_height,
    output sq_stage_t       sq
);

    localparam int LimW = 17;

    logic [CfgW-1:0]          w_sat;
    logic [CfgW-1:0]          h_sat;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic signed [2*DeltaW-1:0] sqx_full;
    logic signed [2*DeltaW-1:0] sqy_full;
    logic [IdxW:0]            idx_full;
    sq_stage_t                sq_reg;
    sq_stage_t                sq_next;

    always_comb begin
        w_sat = (LimW'(image_width) > LimW'(MAX_SIDE)) ? CfgW'(MAX_SIDE) : image_width;
        h_sat = (LimW'(image_height) > LimW'(MAX_SIDE)) ? CfgW'(MAX_SIDE) : image_height;
        dx = $signed({1'b0, pix.x}) - $signed({1'b0, w_sat[CfgW-1:1]});
        dy = $signed({1'b0, pix.y}) - $signed({1'b0, h_sat[CfgW-1:1]});
        sqx_full = dx * dx;
        sqy_full = dy * dy;
        idx_full = (IdxW+1)'(pix.y) * (IdxW+1)'(w_sat) + (IdxW+1)'(pix.x);
        sq_next.sq_x        = sqx_full[SqW-1:0];
        sq_next.sq_y        = sqy_full[SqW-1:0];
        sq_next.dxy         = SumW'(dx) + SumW'(dy);
        sq_next.idx         = idx_full[IdxW-1:0];
        sq_next.frame_start = pix.frame_start;
    end

    always_ff @(posedge aclk) begin
        if (ld.sq) begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

FILE: src/rmpg_ring.sv
// ----------------------------------------------------------------------------
// Ring mask distance stages
// Sum of squares divided by fifteen, then the wrapped ring phase.
// ----------------------------------------------------------------------------
module rmpg_ring import rmpg_pkg::*; (
    input  logic        aclk,
    input  stage_load_t ld,
    input  sq_stage_t   sq,
    output v_stage_t    vs
);

    localparam int D2W      = 25;
    localparam int RecipW   = 26;
    localparam int RecipSh  = 29;
    localparam int ProdW    = D2W + RecipW;
    localparam int SW       = 23;
    localparam logic [RecipW-1:0]  RecipFifteen = 26'd35791395;
    localparam logic signed [SW-1:0] WrapBias   = 23'sd8216;

    logic [D2W-1:0]          d2;
    logic [ProdW-1:0]        prod;
    logic signed [SW-1:0]    s_val;
    q_stage_t                q_reg;
    q_stage_t                q_next;
    v_stage_t                v_reg;
    v_stage_t                v_next;

    always_comb begin
        d2   = D2W'(sq.sq_x) + D2W'(sq.sq_y);
        prod = ProdW'(d2) * ProdW'(RecipFifteen);
        q_next.q           = prod[RecipSh +: QuotW];
        q_next.dxy         = sq.dxy;
        q_next.idx         = sq.idx;
        q_next.frame_start = sq.frame_start;
    end

    always_comb begin
        s_val = SW'(q_reg.dxy) + $signed({1'b0, q_reg.q});
        v_next.v           = (s_val < 0) ? ResW'(s_val + WrapBias) : ResW'(s_val);
        v_next.idx         = q_reg.idx;
        v_next.frame_start = q_reg.frame_start;
    end

    always_ff @(posedge aclk) begin
        if (ld.q) begin
            q_reg <= q_next;
        end
        if (ld.v) begin
            v_reg <= v_next;
        end
    end

    assign vs = v_reg;

endmodule

FILE: src/rmpg_black_count.sv
// ----------------------------------------------------------------------------
// Ring mask decision and black pixel counter
// Phase modulo forty, mask bit, compacted slot and running total.
// ----------------------------------------------------------------------------
`include "ring_mask_pixel_generator_macros.svh"

module rmpg_black_count import rmpg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  stage_load_t ld,
    input  v_stage_t    vs,
    output out_stage_t  result
);

    logic [19:0]     u;
    logic [6:0]      nib_sum;
    logic [4:0]      fold;
    logic [2:0]      rem5;
    logic            keep;
    logic [CntW-1:0] base;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    out_stage_t      out_reg;
    out_stage_t      out_next;

    always_comb begin
        u = 20'(vs.v[ResW-1:3]);
        nib_sum = 7'(u[3:0]) + 7'(u[7:4]) + 7'(u[11:8]) + 7'(u[15:12]) + 7'(u[19:16]);
        fold = 5'(nib_sum[3:0]) + 5'(nib_sum[6:4]);
        priority if (fold >= 5'd20) begin
            rem5 = 3'(fold - 5'd20);
        end else if (fold >= 5'd15) begin
            rem5 = 3'(fold - 5'd15);
        end else if (fold >= 5'd10) begin
            rem5 = 3'(fold - 5'd10);
        end else if (fold >= 5'd5) begin
            rem5 = 3'(fold - 5'd5);
        end else begin
            rem5 = 3'(fold);
        end
        keep = (rem5 < 3'd2) || ((rem5 == 3'd2) && (vs.v[2:0] < 3'd4));
    end

    always_comb begin
        base     = vs.frame_start ? '0 : cnt_reg;
        cnt_next = (!keep && !(&base)) ? base + 1'b1 : base;
        out_next.mask_bit    = keep;
        out_next.pixel_index = vs.idx;
        out_next.black_slot  = keep ? '0 : base[IdxW-1:0];
        out_next.black_total = cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ld.out) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.out) begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

    `RMPG_ASSERT_NEXT(a_frame_restart, aclk, aresetn, ld.out && vs.frame_start, cnt_reg <= 25'd1)
    `RMPG_ASSERT_NEXT(a_total_tracks, aclk, aresetn, ld.out, out_reg.black_total == cnt_reg)

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring mask pixel generator testbench
// A short table of directed pixels and size changes is followed by raster
// scans over corner and random frame sizes, mixed with stray pixels. Both
// stream sides idle at random. Each result is checked against a table value
// or a behavioral copy of the ring mask, linear index and black pixel counter.
// ----------------------------------------------------------------------------
module testbench;
    import rmpg_pkg::*;

    localparam int MaxSide    = 4096;
    localparam int ItemTarget = 1500;
    localparam int StallLimit = 2000;
    localparam int HoldCycles = 300;
    localparam int SettleWait = 8;

    localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_SET_WIDTH,
        OP_SET_HEIGHT
    } row_op_t;

    // arg_a is the column or the register value, arg_b the row
    typedef struct packed {
        row_op_t           op;
        logic [CfgW-1:0]   arg_a;
        logic [CoordW-1:0] arg_b;
        logic              frame_start;
        logic              known;
        out_stage_t        want;
    } stim_row_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr    = '0;
    logic [CfgW-1:0]     cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata     = '0;
    logic                s_tuser     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;

    out_stage_t      due_pixels[$];
    stim_row_t       stim_table[$];
    logic [CfgW-1:0] width_reg  = 13'd640;
    logic [CfgW-1:0] height_reg = 13'd480;
    logic [CntW-1:0] black_count = '0;

    int pixels_sent    = 0;
    int results_seen   = 0;
    int kept_seen      = 0;
    int black_seen     = 0;
    int settings_used  = 0;
    int fail_count     = 0;
    int hold_left      = 0;
    bit held_off       = 1'b0;
    int stuck_cycles   = 0;

    ring_mask_pixel_generator #(
        .MAX_SIDE(MaxSide)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic out_stage_t compute_ring_pixel(logic [CoordW-1:0] x,
                                                      logic [CoordW-1:0] y,
                                                      logic frame_start);
        logic [31:0] w, h, dx, dy, d2, acc, lin;
        out_stage_t  r;
        w   = (width_reg > MaxSide) ? 32'(MaxSide) : 32'(width_reg);
        h   = (height_reg > MaxSide) ? 32'(MaxSide) : 32'(height_reg);
        dx  = 32'(x) - (w >> 1);
        dy  = 32'(y) - (h >> 1);
        d2  = dx * dx + dy * dy;
        acc = dx + dy + d2 / 32'd15;
        lin = 32'(y) * w + 32'(x);
        r.mask_bit    = (acc % 32'd40) < 32'd20;
        r.pixel_index = lin[IdxW-1:0];
        r.black_slot  = '0;
        if (frame_start) begin
            black_count = '0;
        end
        if (!r.mask_bit) begin
            r.black_slot = black_count[IdxW-1:0];
            if (black_count < CountMax) begin
                black_count = black_count + 1'b1;
            end
        end
        r.black_total = black_count;
        return r;
    endfunction

    function automatic void add_row(row_op_t op, int a, int b = 0, bit fs = 0, bit known = 0,
                                    int mask = 0, int idx = 0, int slot = 0, int total = 0);
        stim_row_t row;
        row.op                = op;
        row.arg_a             = a[CfgW-1:0];
        row.arg_b             = b[CoordW-1:0];
        row.frame_start       = fs;
        row.known             = known;
        row.want.mask_bit     = mask[0];
        row.want.pixel_index  = idx[IdxW-1:0];
        row.want.black_slot   = slot[IdxW-1:0];
        row.want.black_total  = total[CntW-1:0];
        stim_table.push_back(row);
    endfunction

    task automatic send_pixel(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                              input logic fs, input bit known = 1'b0,
                              input out_stage_t want = '0);
        out_stage_t predicted;
        while (!(pixels_sent >= 700 && pixels_sent < 1000) && $urandom_range(0, 99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= fs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = compute_ring_pixel(x, y, fs);
        due_pixels.push_back(known ? want : predicted);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgW-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_pixels.size() != 0) @(posedge aclk);
        repeat (SettleWait) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == RegWidth) begin
            width_reg = value;
        end else begin
            height_reg = value;
        end
    endtask

    always @(posedge aclk) begin
        out_stage_t want;
        out_stage_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.mask_bit    = m_tuser;
            got.pixel_index = m_tdata[IdxW-1:0];
            got.black_slot  = m_tdata[2*IdxW-1:IdxW];
            got.black_total = m_tdata[2*IdxW+CntW-1:2*IdxW];
            if (due_pixels.size() == 0) begin
                $error("result with no pixel pending: index %0d", got.pixel_index);
                fail_count++;
            end else begin
                want = due_pixels.pop_front();
                if (got.mask_bit !== want.mask_bit) begin
                    $error("mask_bit: expected %0d, got %0d", want.mask_bit, got.mask_bit);
                    fail_count++;
                end
                if (got.pixel_index !== want.pixel_index) begin
                    $error("pixel_index: expected %0d, got %0d",
                           want.pixel_index, got.pixel_index);
                    fail_count++;
                end
                if (got.black_slot !== want.black_slot) begin
                    $error("black_slot: expected %0d, got %0d", want.black_slot, got.black_slot);
                    fail_count++;
                end
                if (got.black_total !== want.black_total) begin
                    $error("black_total: expected %0d, got %0d",
                           want.black_total, got.black_total);
                    fail_count++;
                end
            end
            results_seen++;
            if (got.mask_bit) begin
                kept_seen++;
            end else begin
                black_seen++;
            end
            if (!held_off && results_seen == 400) begin
                held_off  = 1'b1;
                hold_left = HoldCycles;
            end
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (results_seen >= 700 && results_seen < 1000) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= StallLimit) begin
            $display("timeout: no item moved for %0d cycles", StallLimit);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int corner_w[6];
        int corner_h[6];
        int w, h, span_w, span_h, scan_x, scan_y, n_items, phase;
        bit first;

        corner_w = '{1, 8191, 0, 4096, 4097, 2};
        corner_h = '{1, 8191, 0, 4097, 4096, 8190};

        add_row(OP_PIXEL, 320, 240, 1, 1, 1, 153920, 0, 0);
        add_row(OP_PIXEL, 0, 0, 0, 1, 0, 0, 0, 1);
        add_row(OP_PIXEL, 4095, 4095, 0);
        add_row(OP_PIXEL, 639, 479, 0);
        add_row(OP_PIXEL, 1, 0, 1);
        add_row(OP_PIXEL, 2730, 1365, 0);
        add_row(OP_PIXEL, 1365, 2730, 0);
        add_row(OP_SET_WIDTH, 8191);
        add_row(OP_SET_HEIGHT, 5000);
        add_row(OP_PIXEL, 4095, 4095, 0);
        add_row(OP_PIXEL, 0, 0, 1);
        add_row(OP_SET_WIDTH, 0);
        add_row(OP_SET_HEIGHT, 0);
        add_row(OP_PIXEL, 37, 4095, 0);
        add_row(OP_PIXEL, 0, 0, 0);
        add_row(OP_SET_WIDTH, 1);
        add_row(OP_SET_HEIGHT, 1);
        add_row(OP_PIXEL, 0, 0, 1, 1, 1, 0, 0, 0);
        add_row(OP_PIXEL, 4095, 0, 0);
        add_row(OP_SET_WIDTH, 4096);
        add_row(OP_SET_HEIGHT, 4096);
        add_row(OP_PIXEL, 2048, 2048, 1, 1, 1, 8390656, 0, 0);
        add_row(OP_PIXEL, 0, 4095, 0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[i]) begin
            case (stim_table[i].op)
                OP_SET_WIDTH: begin
                    write_reg(RegWidth, stim_table[i].arg_a);
                    settings_used++;
                end
                OP_SET_HEIGHT: begin
                    write_reg(RegHeight, stim_table[i].arg_a);
                end
                default: begin
                    send_pixel(stim_table[i].arg_a[CoordW-1:0], stim_table[i].arg_b,
                               stim_table[i].frame_start, stim_table[i].known,
                               stim_table[i].want);
                end
            endcase
        end

        phase = 0;
        while (pixels_sent < ItemTarget) begin
            if (phase < 6) begin
                w = corner_w[phase];
                h = corner_h[phase];
            end else if ($urandom_range(0, 9) < 7) begin
                w = $urandom_range(1, 48);
                h = $urandom_range(1, 48);
            end else begin
                w = $urandom_range(0, 8191);
                h = $urandom_range(0, 8191);
            end
            write_reg(RegWidth, w[CfgW-1:0]);
            write_reg(RegHeight, h[CfgW-1:0]);
            settings_used++;
            span_w  = (w == 0) ? 1 : ((w > MaxSide) ? MaxSide : w);
            span_h  = (h == 0) ? 1 : ((h > MaxSide) ? MaxSide : h);
            scan_x  = $urandom_range(0, span_w - 1);
            scan_y  = $urandom_range(0, span_h - 1);
            first   = 1'b1;
            n_items = $urandom_range(60, 200);
            repeat (n_items) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_pixel(CoordW'($urandom_range(0, 4095)),
                               CoordW'($urandom_range(0, 4095)),
                               $urandom_range(0, 7) == 0);
                end else begin
                    send_pixel(CoordW'(scan_x), CoordW'(scan_y), first);
                    first = 1'b0;
                    scan_x++;
                    if (scan_x >= span_w) begin
                        scan_x = 0;
                        scan_y++;
                        if (scan_y >= span_h) begin
                            scan_y = 0;
                            first  = 1'b1;
                        end
                    end
                end
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (due_pixels.size() != 0) @(posedge aclk);
        repeat (SettleWait) @(posedge aclk);
        if (due_pixels.size() != 0) begin
            $error("%0d results never arrived", due_pixels.size());
            fail_count++;
        end
        $display("run covered %0d pixels over %0d frame size settings", pixels_sent,
                 settings_used);
        $display("results: %0d kept, %0d black, %0d mismatches", kept_seen, black_seen,
                 fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
